// ----- src/sensor_node_table_update_macros.svh -----
// Assertion macros used by the checker file snu_checker.sv.
`ifndef SENSOR_NODE_TABLE_UPDATE_MACROS_SVH
`define SENSOR_NODE_TABLE_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SNU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snu: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SNU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snu: next-cycle check failed");

`endif

// ----- src/snu_pkg.sv -----
package snu_pkg;

    localparam logic [31:0] LOG_INTERVAL_RESET = 32'd300000;
    localparam logic [7:0]  MOTION_ON          = 8'd1;
    localparam logic [30:0] FLOAT_ZERO_MAG     = 31'd0;

    // configuration port
    localparam int   PADDR_W          = 3;
    localparam logic REG_LOG_INTERVAL = 1'b0;

    // shared compare unit
    localparam int CMP_W = 48;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

    // input transaction payload, lowest field in the lowest bits
    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [7:0]  signal_dbm;
        logic [31:0]        reported_triggers;
        logic [31:0]        sender_uptime_ms;
        logic [31:0]        reported_motion_ms;
        logic [31:0]        gas_bits;
        logic [31:0]        pressure_bits;
        logic [31:0]        humidity_bits;
        logic [31:0]        temperature_bits;
        logic [7:0]         motion;
        logic [47:0]        src_mac;
    } in_data_t;

    localparam int IN_W = $bits(in_data_t);

    // result transaction payload
    typedef struct packed {
        logic [2:0]  spare;
        logic [4:0]  node_total;
        logic        env_absent;
        logic        log_request;
        logic [31:0] motion_uptime_ms;
        logic [31:0] trigger_total;
        logic        evicted;
        logic        was_new;
        logic [3:0]  node_slot;
    } result_t;

    localparam int OUT_W = $bits(result_t);

    // the part of a report kept while it is being processed
    typedef struct packed {
        logic [47:0]       src_mac;
        logic [7:0]        motion;
        logic [31:0]       reported_motion_ms;
        logic [31:0]       sender_uptime_ms;
        logic [31:0]       reported_triggers;
        logic              has_triggers;
        logic signed [7:0] signal_dbm;
        logic [31:0]       now_ms;
        logic              env_absent;
    } item_t;

    // one node table entry
    typedef struct packed {
        logic [47:0]       mac;
        logic [31:0]       seen_ms;
        logic [31:0]       triggers;
        logic [7:0]        motion;
        logic [31:0]       motion_uptime;
        logic signed [7:0] rssi;
        logic [31:0]       env_logged_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MREAD = 7'b0000010,
        S_MCHK  = 7'b0000100,
        S_MISS  = 7'b0001000,
        S_LREAD = 7'b0010000,
        S_LCHK  = 7'b0100000,
        S_CALC  = 7'b1000000
    } state_t;

endpackage

// ----- src/snu_ram.sv -----
module snu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/snu_cmp.sv -----
module snu_cmp (
    input  logic [snu_pkg::CMP_W-1:0] a,
    input  logic [snu_pkg::CMP_W-1:0] b,
    output snu_pkg::cmp_res_t         res
);

    import snu_pkg::*;

    logic [CMP_W:0] diff;

    // one subtractor gives both equality and unsigned less-than (borrow)
    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.lt = diff[CMP_W];
    assign res.eq = (diff[CMP_W-1:0] == '0);

endmodule

// ----- src/sensor_node_table_update.sv -----
// Sensor node table update.
// Input channel s_axis_*: one transaction is one received sensor report.
// Output channel m_axis_*: one result transaction per report (slot used,
// new/evicted flags, trigger count, motion uptime, log request, node count).
// APB port: register 0 (byte address 0) is log_interval_ms, reset 300000.
// Timing: the table sits in one RAM with a registered read, and each entry
// visit has two steps (address, then compare in the shared 48-bit
// subtract/compare unit). A hit ends the match scan at its slot; a miss scans
// every occupied entry, and with a full table a least-recent scan follows.
// One report at a time: s_axis_tready is high only while the sequencer idles,
// and it rises together with m_axis_tvalid when a result is finished.
// A finished result waits in the output register while the next report is
// taken; a result held up by a stalled receiver waits in the final step.
// Reset empties the table (count to zero), restores the interval and drops
// any pending result; entry contents need no clearing.
module sensor_node_table_update #(
    parameter int NODE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // src_mac, motion, temperature_bits, humidity_bits, pressure_bits,
    // gas_bits, reported_motion_ms, sender_uptime_ms, reported_triggers,
    // signal_dbm, now_ms
    input  logic [snu_pkg::IN_W-1:0]    s_axis_tdata,
    // has_triggers
    input  logic [0:0]                  s_axis_tuser,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // node_slot, was_new, evicted, trigger_total, motion_uptime_ms,
    // log_request, env_absent, node_total, three zero pad bits
    output logic [snu_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import snu_pkg::*;

    localparam int SW = $clog2(NODE_SLOTS);
    localparam int CW = $clog2(NODE_SLOTS + 1);

    // control state
    state_t          state_reg,     state_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic [31:0]     interval_reg,  interval_next;
    logic            out_valid_reg, out_valid_next;

    // working payload
    logic [CW-1:0]   k_reg,         k_next;
    logic [SW-1:0]   slot_reg,      slot_next;
    logic [31:0]     best_seen_reg, best_seen_next;
    logic            was_new_reg,   was_new_next;
    logic            evicted_reg,   evicted_next;
    item_t           item_reg,      item_next;
    entry_t          cur_reg,       cur_next;
    result_t         out_reg,       out_next;

    in_data_t        in_data;
    entry_t          rd_entry;
    entry_t          wr_entry;
    logic            ram_we;
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    cmp_res_t        cmp_res;
    logic [CW-1:0]   k_inc;
    logic            k_more;

    // update arithmetic
    logic            motion_on;
    logic [31:0]     mu_new;
    logic [31:0]     trig_new;
    logic [31:0]     elapsed;
    logic            log_req;
    logic [CW-1:0]   count_upd;
    logic [CW+4:0]   total_ext;
    logic [SW+3:0]   slot_ext;

    assign in_data = in_data_t'(s_axis_tdata);

    snu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (wr_entry),
        .raddr (k_reg[SW-1:0]),
        .rdata (rd_entry)
    );

    // match scan compares MACs; least-recent scan compares last-seen times
    assign cmp_a = (state_reg == S_LCHK) ? {16'd0, rd_entry.seen_ms} : rd_entry.mac;
    assign cmp_b = (state_reg == S_LCHK) ? {16'd0, best_seen_reg} : item_reg.src_mac;

    snu_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign k_inc  = k_reg + CW'(1);
    assign k_more = (k_inc < count_reg);

    // new entry contents from the entry as found (or freshly started)
    always_comb
    begin
        motion_on = (item_reg.motion == MOTION_ON);

        if (item_reg.reported_motion_ms != 32'd0)
        begin
            mu_new = item_reg.reported_motion_ms;
        end
        else if (motion_on)
        begin
            mu_new = item_reg.sender_uptime_ms;
        end
        else
        begin
            mu_new = cur_reg.motion_uptime;
        end

        if (item_reg.has_triggers)
        begin
            trig_new = item_reg.reported_triggers;
        end
        else if (motion_on && (cur_reg.motion == 8'd0))
        begin
            trig_new = cur_reg.triggers + 32'd1;
        end
        else
        begin
            trig_new = cur_reg.triggers;
        end

        // wrapping difference against the last environment log time
        elapsed = item_reg.now_ms - cur_reg.env_logged_ms;
        log_req = motion_on ||
                  (!item_reg.env_absent &&
                   ((cur_reg.env_logged_ms == 32'd0) || (elapsed >= interval_reg)));

        wr_entry.mac           = item_reg.src_mac;
        wr_entry.seen_ms       = item_reg.now_ms;
        wr_entry.triggers      = trig_new;
        wr_entry.motion        = item_reg.motion;
        wr_entry.motion_uptime = mu_new;
        wr_entry.rssi          = item_reg.signal_dbm;
        wr_entry.env_logged_ms = (log_req && !item_reg.env_absent) ?
                                 item_reg.now_ms : cur_reg.env_logged_ms;

        count_upd = (was_new_reg && !evicted_reg) ? count_reg + CW'(1) : count_reg;
        total_ext = {5'd0, count_upd};
        slot_ext  = {4'd0, slot_reg};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        interval_next  = interval_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        slot_next      = slot_reg;
        best_seen_next = best_seen_reg;
        was_new_next   = was_new_reg;
        evicted_next   = evicted_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;

        // register write, to be done only while idle; the block itself does not enforce it
        if (psel && penable && pwrite && (paddr[2] == REG_LOG_INTERVAL))
        begin
            interval_next = pwdata;
        end

        // drop the result once the receiver has taken it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    item_next.src_mac            = in_data.src_mac;
                    item_next.motion             = in_data.motion;
                    item_next.reported_motion_ms = in_data.reported_motion_ms;
                    item_next.sender_uptime_ms   = in_data.sender_uptime_ms;
                    item_next.reported_triggers  = in_data.reported_triggers;
                    item_next.has_triggers       = s_axis_tuser[0];
                    item_next.signal_dbm         = in_data.signal_dbm;
                    item_next.now_ms             = in_data.now_ms;
                    // plus and minus zero both count as no reading
                    item_next.env_absent =
                        (in_data.temperature_bits[30:0] == FLOAT_ZERO_MAG) &&
                        (in_data.humidity_bits[30:0]    == FLOAT_ZERO_MAG) &&
                        (in_data.pressure_bits[30:0]    == FLOAT_ZERO_MAG) &&
                        (in_data.gas_bits[30:0]         == FLOAT_ZERO_MAG);
                    k_next       = '0;
                    was_new_next = 1'b0;
                    evicted_next = 1'b0;
                    state_next   = (count_reg == '0) ? S_MISS : S_MREAD;
                end
            end

            S_MREAD:
            begin
                state_next = S_MCHK;
            end

            S_MCHK:
            begin
                if (cmp_res.eq)
                begin
                    slot_next  = k_reg[SW-1:0];
                    cur_next   = rd_entry;
                    state_next = S_CALC;
                end
                else if (k_more)
                begin
                    k_next     = k_inc;
                    state_next = S_MREAD;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end

            S_MISS:
            begin
                was_new_next           = 1'b1;
                cur_next               = '0;
                cur_next.triggers      = item_reg.has_triggers ?
                                         item_reg.reported_triggers : 32'd0;
                if (count_reg < CW'(NODE_SLOTS))
                begin
                    slot_next  = count_reg[SW-1:0];
                    state_next = S_CALC;
                end
                else
                begin
                    evicted_next = 1'b1;
                    k_next       = '0;
                    state_next   = S_LREAD;
                end
            end

            S_LREAD:
            begin
                state_next = S_LCHK;
            end

            S_LCHK:
            begin
                // strict less-than keeps the lowest index on ties
                if ((k_reg == '0) || cmp_res.lt)
                begin
                    slot_next      = k_reg[SW-1:0];
                    best_seen_next = rd_entry.seen_ms;
                end
                if (k_more)
                begin
                    k_next     = k_inc;
                    state_next = S_LREAD;
                end
                else
                begin
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    ram_we                    = 1'b1;
                    count_next                = count_upd;
                    out_next.spare            = '0;
                    out_next.node_total       = total_ext[4:0];
                    out_next.env_absent       = item_reg.env_absent;
                    out_next.log_request      = log_req;
                    out_next.motion_uptime_ms = mu_new;
                    out_next.trigger_total    = trig_new;
                    out_next.evicted          = evicted_reg;
                    out_next.was_new          = was_new_reg;
                    out_next.node_slot        = slot_ext[3:0];
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            interval_reg  <= LOG_INTERVAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        slot_reg      <= slot_next;
        best_seen_reg <= best_seen_next;
        was_new_reg   <= was_new_next;
        evicted_reg   <= evicted_next;
        item_reg      <= item_next;
        cur_reg       <= cur_next;
        out_reg       <= out_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_LOG_INTERVAL) ? interval_reg : 32'd0;

endmodule

// ----- src/snu_checker.sv -----
`include "sensor_node_table_update_macros.svh"

module snu_checker #(
    parameter int NODE_SLOTS = 16
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [snu_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready
);

    import snu_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata);

    // a stalled result holds its value
    `SNU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one report at a time: ready drops right after a report is taken
    `SNU_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // an appended node lands just past the previous last entry
    `SNU_ASSERT_IMPL(a_append_slot, m_axis_tvalid && res.was_new && !res.evicted && (NODE_SLOTS <= 16), res.node_slot == 4'(res.node_total - 5'd1))

    // eviction only happens with a full table
    `SNU_ASSERT_IMPL(a_evict_full, m_axis_tvalid && res.evicted && (NODE_SLOTS <= 16), res.was_new && (res.node_total == 5'(NODE_SLOTS)))

endmodule

bind sensor_node_table_update snu_checker #(
    .NODE_SLOTS (NODE_SLOTS)
) u_snu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ----- tb/sensor_node_table_update_checker.sv -----
`timescale 1ns / 1ps

module sensor_node_table_update_checker #(
    parameter int NODE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  snu_pkg::in_data_t           s_axis_tdata,
    input  logic [0:0]                  s_axis_tuser,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [snu_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          outstanding
);
    import snu_pkg::*;

    localparam logic [PADDR_W-1:0] LOG_INTERVAL_ADDR = {REG_LOG_INTERVAL, 2'b00};

    // shadow of the block's node table and interval register
    int          node_count;
    logic [31:0] log_interval;
    logic [47:0] node_mac       [NODE_SLOTS];
    logic [31:0] node_seen      [NODE_SLOTS];
    logic [31:0] node_triggers  [NODE_SLOTS];
    logic [7:0]  node_motion    [NODE_SLOTS];
    logic [31:0] node_motion_up [NODE_SLOTS];
    logic [31:0] node_env_log   [NODE_SLOTS];

    result_t expected_results[$];

    function automatic bit float_is_zero(input logic [31:0] bits);
        return bits[30:0] == FLOAT_ZERO_MAG;
    endfunction

    task automatic predict_table_update(input in_data_t r, input logic carried,
                                        output result_t res);
        int         slot;
        bit         found;
        bit         evict;
        bit         no_env;
        bit         log_req;
        logic [7:0] prev_motion;
        slot  = 0;
        found = 1'b0;
        evict = 1'b0;
        for (int k = 0; k < node_count; k++)
            if (!found && node_mac[k] == r.src_mac)
            begin
                slot  = k;
                found = 1'b1;
            end
        if (!found)
        begin
            if (node_count >= NODE_SLOTS)
            begin
                // least recently seen, plain unsigned compare, lowest index on ties
                evict = 1'b1;
                for (int k = 1; k < node_count; k++)
                    if (node_seen[k] < node_seen[slot])
                        slot = k;
            end
            else
            begin
                slot = node_count;
                node_count++;
            end
            node_mac[slot]       = r.src_mac;
            node_triggers[slot]  = carried ? r.reported_triggers : 32'd0;
            node_motion[slot]    = 8'd0;
            node_motion_up[slot] = 32'd0;
            node_env_log[slot]   = 32'd0;
        end
        prev_motion     = node_motion[slot];
        node_seen[slot] = r.now_ms;
        if (r.reported_motion_ms != 32'd0)
            node_motion_up[slot] = r.reported_motion_ms;
        else if (r.motion == MOTION_ON)
            node_motion_up[slot] = r.sender_uptime_ms;
        if (carried)
            node_triggers[slot] = r.reported_triggers;
        else if (r.motion == MOTION_ON && prev_motion == 8'd0)
            node_triggers[slot] = node_triggers[slot] + 32'd1;
        node_motion[slot] = r.motion;
        no_env = float_is_zero(r.temperature_bits) && float_is_zero(r.humidity_bits) &&
                 float_is_zero(r.pressure_bits) && float_is_zero(r.gas_bits);
        log_req = (r.motion == MOTION_ON) ||
                  (!no_env && (node_env_log[slot] == 32'd0 ||
                               32'(r.now_ms - node_env_log[slot]) >= log_interval));
        if (log_req && !no_env)
            node_env_log[slot] = r.now_ms;
        res                  = '0;
        res.node_slot        = 4'(slot);
        res.was_new          = !found;
        res.evicted          = evict;
        res.trigger_total    = node_triggers[slot];
        res.motion_uptime_ms = node_motion_up[slot];
        res.log_request      = log_req;
        res.env_absent       = no_env;
        res.node_total       = 5'(node_count);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            node_count   = 0;
            log_interval = LOG_INTERVAL_RESET;
            mismatches   = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no report outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("node_slot", 32'(want.node_slot), 32'(got.node_slot));
                    check_field("was_new", 32'(want.was_new), 32'(got.was_new));
                    check_field("evicted", 32'(want.evicted), 32'(got.evicted));
                    check_field("trigger_total", want.trigger_total, got.trigger_total);
                    check_field("motion_uptime_ms", want.motion_uptime_ms,
                                got.motion_uptime_ms);
                    check_field("log_request", 32'(want.log_request),
                                32'(got.log_request));
                    check_field("env_absent", 32'(want.env_absent), 32'(got.env_absent));
                    check_field("node_total", 32'(want.node_total), 32'(got.node_total));
                    check_field("spare", 32'(want.spare), 32'(got.spare));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_table_update(s_axis_tdata, s_axis_tuser[0], want);
                expected_results.push_back(want);
            end
            if (psel && penable && pready && paddr == LOG_INTERVAL_ADDR)
            begin
                if (pwrite)
                    log_interval = pwdata;
                else
                    check_field("log_interval_ms", log_interval, prdata);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- tb/sensor_node_table_update_tb.sv -----
`timescale 1ns / 1ps

module sensor_node_table_update_tb;
    import snu_pkg::*;

    localparam int NODE_SLOTS = 16;
    // worst quiet stretch: a sender gap between bursts, a full-table miss with both scans
    // and a long receiver stall, taken many times over
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [PADDR_W-1:0] LOG_INTERVAL_ADDR = {REG_LOG_INTERVAL, 2'b00};
    localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // report channel; tdata fields from the lowest bit up: src_mac, motion,
    // temperature_bits, humidity_bits, pressure_bits, gas_bits,
    // reported_motion_ms, sender_uptime_ms, reported_triggers, signal_dbm, now_ms
    in_data_t    s_axis_tdata = '0;
    // tuser: has_triggers
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;

    // result channel; tdata fields from the lowest bit up: node_slot, was_new,
    // evicted, trigger_total, motion_uptime_ms, log_request, env_absent,
    // node_total, zero pad
    logic [OUT_W-1:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int mismatch_count;
    int reports_outstanding;

    // sender pacing and stimulus state
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [47:0] mac_pool [48];

    // receiver stall pattern
    int pattern_mode = 0;
    int pattern_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sensor_node_table_update #(
        .NODE_SLOTS(NODE_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sensor_node_table_update_checker #(
        .NODE_SLOTS(NODE_SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mismatches   (mismatch_count),
        .outstanding  (reports_outstanding)
    );

    // Receiver: pick a stall pattern, hold it for a random stretch, then pick again.
    // Mode 0 never stalls, 1 stalls half the time, 2 mostly stalls, 3 stalls in
    // solid blocks.
    always @(negedge clk)
    begin
        if (pattern_left == 0)
        begin
            pattern_mode <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(20, 150);
        end
        else
        begin
            pattern_left <= pattern_left - 1;
        end
        case (pattern_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (pattern_left[4:3] != 2'b00);
        endcase
    end

    // Watchdog: end the run once nothing has moved on any port for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // One register access: setup cycle, then access cycle until pready.
    // Call at a falling edge; returns at a falling edge with the bus idle.
    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LOG_INTERVAL_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one report and hold it until the block takes the transaction.
    // Between bursts, when gaps_on is set, drop tvalid for a random gap; within a burst keep it high
    // and only swap the payload, so tvalid is never lowered and raised at once.
    task automatic send_report(input in_data_t r, input logic carried);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 60);
        end
        burst_left--;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= r;
        s_axis_tuser  <= carried;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop tvalid and hold off until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (reports_outstanding != 0)
            @(negedge clk);
    endtask

    function automatic in_data_t report(input logic [47:0] mac, input logic [7:0] motion,
                                        input logic [31:0] env, input logic [31:0] now);
        in_data_t r;
        r                  = '0;
        r.src_mac          = mac;
        r.motion           = motion;
        r.temperature_bits = env;
        r.humidity_bits    = env;
        r.pressure_bits    = env;
        r.gas_bits         = env;
        r.now_ms           = now;
        return r;
    endfunction

    // Environment word: plenty of both zero encodings, otherwise any bit pattern.
    function automatic logic [31:0] env_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random report: mostly nodes drawn from a pool of known MACs so that hits,
    // motion edges and log intervals build up per node, with some strangers to
    // force evictions. Local time mostly advances; now and then it stands
    // still (eviction ties), drops to zero or jumps anywhere.
    task automatic random_report(input int pool, output in_data_t r, output logic carried);
        int roll;
        r = '0;
        if ($urandom_range(0, 9) == 0)
            r.src_mac = {16'($urandom), 32'($urandom)};
        else
            r.src_mac = mac_pool[$urandom_range(0, pool - 1)];
        roll = $urandom_range(0, 19);
        if (roll < 9)
            r.motion = MOTION_ON;
        else if (roll < 17)
            r.motion = 8'd0;
        else
            r.motion = 8'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            r.temperature_bits = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
            r.humidity_bits    = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
            r.pressure_bits    = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
            r.gas_bits         = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
        end
        else
        begin
            r.temperature_bits = env_word();
            r.humidity_bits    = env_word();
            r.pressure_bits    = env_word();
            r.gas_bits         = env_word();
        end
        r.reported_motion_ms = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
        r.sender_uptime_ms   = $urandom;
        carried              = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            r.reported_triggers = 32'hFFFF_FFFF;
        else if (roll == 1)
            r.reported_triggers = 32'd0;
        else
            r.reported_triggers = $urandom;
        r.signal_dbm = 8'($urandom);
        roll = $urandom_range(0, 19);
        if (roll == 0)
            r.now_ms = 32'd0;
        else if (roll == 1)
            r.now_ms = $urandom;
        else
        begin
            if (roll != 2)
                clock_ms = clock_ms + 32'($urandom_range(1, 60000));
            r.now_ms = clock_ms;
        end
    endtask

    initial
    begin : stimulus
        in_data_t    r;
        logic        carried;
        logic [31:0] interval;
        int          pool;
        int          count;

        mac_pool[0] = 48'h0;
        mac_pool[1] = MAC_ONES;
        for (int i = 2; i < 48; i++)
            mac_pool[i] = {16'($urandom), 32'($urandom)};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // the interval register must come out of reset at its default
        apb_access(1'b0, 32'd0);

        // Directed part, reset interval.
        // First node: motion at time zero with no environment data; extreme
        // uptime and signal strength.
        r = report(48'h0, MOTION_ON, 32'h0, 32'd0);
        r.sender_uptime_ms = 32'hFFFF_FFFF;
        r.signal_dbm       = -8'sd128;
        send_report(r, 1'b0);
        // negative zeros everywhere still count as absent; carried count at its top
        r = report(MAC_ONES, 8'd0, 32'h8000_0000, 32'd10);
        r.reported_triggers = 32'hFFFF_FFFF;
        r.signal_dbm        = 8'sd127;
        send_report(r, 1'b1);
        // rising motion with no carried count wraps the trigger counter
        r = report(MAC_ONES, MOTION_ON, 32'h8000_0000, 32'd20);
        r.reported_motion_ms = 32'hFFFF_FFFF;
        send_report(r, 1'b0);
        // motion byte other than one is no motion; env at time zero keeps log time zero
        r = report(MAC_ONES, 8'hFF, 32'h7FFF_FFFF, 32'd0);
        r.temperature_bits = 32'hFFFF_FFFF;
        send_report(r, 1'b0);
        // log time still zero, so the request is forced again
        send_report(report(MAC_ONES, 8'd0, 32'h0000_0001, 32'd5), 1'b0);
        // one millisecond short of the interval: no request
        send_report(report(MAC_ONES, 8'd0, 32'h0000_0001, 32'd300004), 1'b0);
        // exactly one interval on, with only one environment word present
        r = report(MAC_ONES, 8'd0, 32'h0, 32'd300005);
        r.gas_bits = 32'h3F80_0000;
        send_report(r, 1'b0);
        // fill the table; every filler is seen at time zero
        for (int i = 0; i < 14; i++)
        begin
            r = report({40'h02_0000_0000, 8'(i)}, i[0] ? MOTION_ON : 8'd0,
                       32'h4120_0000, 32'd0);
            r.reported_motion_ms = i;
            r.reported_triggers  = i;
            send_report(r, i[0]);
        end
        // full table: ties at zero go to the lowest slot, then the next zero
        send_report(report(48'h8000_0000_0000, MOTION_ON, 32'h0, 32'd1), 1'b0);
        send_report(report(48'h8000_0000_0001, 8'd0, 32'h4120_0000, 32'd7), 1'b0);
        drain_results();

        // Random phases, each under its own interval setting. Registers only
        // change with nothing outstanding; read each setting back.
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    interval = 32'd0;
                    pool     = 14;
                    count    = 150;
                end
                1:
                begin
                    interval = 32'hFFFF_FFFF;
                    pool     = 40;
                    count    = 150;
                end
                2:
                begin
                    interval = 32'd1000;
                    pool     = 20;
                    count    = 200;
                end
                3:
                begin
                    interval = $urandom_range(1000, 600000);
                    pool     = 16;
                    count    = 200;
                    // run local time across the 2^32 wrap
                    clock_ms = 32'hFFF0_0000;
                end
                default:
                begin
                    interval = LOG_INTERVAL_RESET;
                    pool     = 48;
                    count    = 150;
                end
            endcase
            // first phase runs back to back; the rest leave gaps between bursts
            gaps_on = (p != 0);
            apb_access(1'b1, interval);
            apb_access(1'b0, 32'd0);
            for (int n = 0; n < count; n++)
            begin
                random_report(pool, r, carried);
                send_report(r, carried);
            end
            drain_results();
        end

        // let any stray result show up before the verdict
        repeat (4 * NODE_SLOTS + 8) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sensor_node_table_update.f -----
+incdir+src
src/snu_pkg.sv
src/snu_ram.sv
src/snu_cmp.sv
src/sensor_node_table_update.sv
src/snu_checker.sv
tb/sensor_node_table_update_checker.sv
tb/sensor_node_table_update_tb.sv
